// File: hdl/ple_pkg.sv
package ple_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 8;
    localparam int RES_W     = 32;
    localparam int CNT_OUT_W = 6;

    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_INSERT       = 3'd1,
        CMD_REMOVE_FIRST = 3'd2,
        CMD_REMOVE_AT    = 3'd3,
        CMD_READ         = 3'd4,
        CMD_WRITE        = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // what every cell of the chain does on a transfer
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_WRITE  = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_ECHO = 2'd1,
        SEL_READ = 2'd2
    } t_res_sel;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

    typedef struct packed {
        t_cell_ctl ctl;
        t_status   status;
        t_res_sel  sel;
        logic      cnt_inc;
        logic      cnt_dec;
    } t_dec;

endpackage

// File: hdl/ple_if.sv
interface ple_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ple_pkg::CMD_W-1:0]           cmd;
    logic [ple_pkg::POS_W-1:0]           position;
    logic signed [ple_pkg::RES_W-1:0]    value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface ple_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ple_pkg::RES_W-1:0]    result_value;
    logic [1:0]                          status;
    logic [ple_pkg::CNT_OUT_W-1:0]       element_count;
    logic                                is_empty;

    modport source (output valid, output result_value, output status,
                    output element_count, output is_empty, input ready);
    modport sink   (input valid, input result_value, input status,
                    input element_count, input is_empty, output ready);
endinterface

// File: hdl/ple_cell.sv
module ple_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  ple_pkg::t_cell_ctl      i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_data,
    input  logic [DATA_WIDTH-1:0]   i_left,
    input  logic [DATA_WIDTH-1:0]   i_right,
    output logic [DATA_WIDTH-1:0]   o_word
);

    localparam logic [ple_pkg::POS_W-1:0] IDX = ple_pkg::POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            ple_pkg::OP_INSERT: begin
                if (IDX > i_ctl.pos) begin
                    n_word = i_left;
                end else if (IDX == i_ctl.pos) begin
                    n_word = i_data;
                end
            end
            ple_pkg::OP_REMOVE: begin
                if (IDX >= i_ctl.pos) begin
                    n_word = i_right;
                end
            end
            ple_pkg::OP_WRITE: begin
                if (IDX == i_ctl.pos) begin
                    n_word = i_data;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// File: hdl/ple_decode.sv
module ple_decode #(
    parameter int CAPACITY = 32
) (
    input  logic [ple_pkg::CMD_W-1:0]        i_cmd,
    input  logic [ple_pkg::POS_W-1:0]        i_position,
    input  logic [$clog2(CAPACITY+1)-1:0]    i_count,
    output ple_pkg::t_dec                    o_dec
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W + 1 : ple_pkg::POS_W + 1;

    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic             w_full;
    logic             w_zero;

    assign w_pos  = CMP_W'(i_position);
    assign w_cnt  = CMP_W'(i_count);
    assign w_full = (w_cnt >= CMP_W'(CAPACITY));
    assign w_zero = (w_cnt == '0);

    always_comb begin
        o_dec.ctl.op  = ple_pkg::OP_HOLD;
        o_dec.ctl.pos = i_position;
        o_dec.status  = ple_pkg::ST_OK;
        o_dec.sel     = ple_pkg::SEL_ZERO;
        o_dec.cnt_inc = 1'b0;
        o_dec.cnt_dec = 1'b0;
        case (ple_pkg::t_cmd'(i_cmd))
            ple_pkg::CMD_APPEND: begin
                o_dec.sel     = ple_pkg::SEL_ECHO;
                o_dec.ctl.pos = w_cnt[ple_pkg::POS_W-1:0];
                if (w_full) begin
                    o_dec.status = ple_pkg::ST_FULL;
                end else begin
                    o_dec.ctl.op  = ple_pkg::OP_INSERT;
                    o_dec.cnt_inc = 1'b1;
                end
            end
            ple_pkg::CMD_INSERT: begin
                o_dec.sel = ple_pkg::SEL_ECHO;
                if (w_pos > w_cnt) begin
                    o_dec.status = ple_pkg::ST_BADPOS;
                end else if (w_full) begin
                    o_dec.status = ple_pkg::ST_FULL;
                end else begin
                    o_dec.ctl.op  = ple_pkg::OP_INSERT;
                    o_dec.cnt_inc = 1'b1;
                end
            end
            ple_pkg::CMD_REMOVE_FIRST: begin
                o_dec.ctl.pos = '0;
                if (w_zero) begin
                    o_dec.status = ple_pkg::ST_EMPTY;
                end else begin
                    o_dec.ctl.op  = ple_pkg::OP_REMOVE;
                    o_dec.sel     = ple_pkg::SEL_READ;
                    o_dec.cnt_dec = 1'b1;
                end
            end
            ple_pkg::CMD_REMOVE_AT: begin
                // empty takes precedence over a bad position
                if (w_zero) begin
                    o_dec.status = ple_pkg::ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    o_dec.status = ple_pkg::ST_BADPOS;
                end else begin
                    o_dec.ctl.op  = ple_pkg::OP_REMOVE;
                    o_dec.sel     = ple_pkg::SEL_READ;
                    o_dec.cnt_dec = 1'b1;
                end
            end
            ple_pkg::CMD_READ: begin
                if (w_pos >= w_cnt) begin
                    o_dec.status = ple_pkg::ST_BADPOS;
                end else begin
                    o_dec.sel = ple_pkg::SEL_READ;
                end
            end
            ple_pkg::CMD_WRITE: begin
                o_dec.sel = ple_pkg::SEL_ECHO;
                if (w_pos >= w_cnt) begin
                    o_dec.status = ple_pkg::ST_BADPOS;
                end else begin
                    o_dec.ctl.op = ple_pkg::OP_WRITE;
                end
            end
            default: begin
                o_dec.status = ple_pkg::ST_BADPOS;
            end
        endcase
    end

endmodule

// File: hdl/positional_list_engine_unit.sv
// The output register holds the result in the cycle after the command transfer.
// Throughput: one command per cycle unless the response stalls. Every cell of the chain
// shifts, loads or holds in the same cycle; any insert or remove is one transfer.
// Reset (synchronous, active low) empties the list and drops the output valid;
// cell words are not cleared and are never read before they are written.
module positional_list_engine_unit #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ple_cmd_if.sink     i_cmd,
    ple_rsp_if.source   o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int EXT_W = (CNT_W > ple_pkg::CNT_OUT_W) ? CNT_W : ple_pkg::CNT_OUT_W;

    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic                            r_valid;
    logic signed [ple_pkg::RES_W-1:0] r_result;
    logic [1:0]                      r_status;
    logic [ple_pkg::CNT_OUT_W-1:0]   r_elem_cnt;
    logic                            r_empty;

    logic                            w_accept;
    ple_pkg::t_dec                   w_dec;
    logic [DATA_WIDTH-1:0]           w_store;
    logic [DATA_WIDTH-1:0]           w_words [CAPACITY];
    logic [DATA_WIDTH-1:0]           w_read_word;
    logic [ple_pkg::RES_W-1:0]       w_read_ext;
    logic [ple_pkg::RES_W-1:0]       w_result;
    logic [EXT_W-1:0]                w_count_ext;

    // no transfer while reset is held
    assign i_cmd.ready = i_rst_n && (!r_valid || o_rsp.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    ple_decode #(
        .CAPACITY (CAPACITY)
    ) u_decode (
        .i_cmd      (i_cmd.cmd),
        .i_position (i_cmd.position),
        .i_count    (r_count),
        .o_dec      (w_dec)
    );

    generate
        if (DATA_WIDTH >= ple_pkg::RES_W) begin : g_wide
            assign w_store    = DATA_WIDTH'($unsigned(i_cmd.value));
            assign w_read_ext = w_read_word[ple_pkg::RES_W-1:0];
        end else begin : g_narrow
            assign w_store    = i_cmd.value[DATA_WIDTH-1:0];
            assign w_read_ext = {{(ple_pkg::RES_W-DATA_WIDTH){w_read_word[DATA_WIDTH-1]}},
                                 w_read_word};
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_store;
            end else begin : g_mid_l
                assign w_left = w_words[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = w_words[gi];
            end else begin : g_mid_r
                assign w_right = w_words[gi+1];
            end
            ple_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_en    (w_accept),
                .i_ctl   (w_dec.ctl),
                .i_data  (w_store),
                .i_left  (w_left),
                .i_right (w_right),
                .o_word  (w_words[gi])
            );
        end
    endgenerate

    assign w_read_word = w_words[w_dec.ctl.pos[IDX_W-1:0]];

    always_comb begin
        case (w_dec.sel)
            ple_pkg::SEL_ECHO: w_result = i_cmd.value;
            ple_pkg::SEL_READ: w_result = w_read_ext;
            default:           w_result = '0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_dec.cnt_inc) begin
            n_count = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (w_dec.cnt_dec) begin
            n_count = r_count - {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

    assign w_count_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result   <= w_result;
            r_status   <= w_dec.status;
            r_elem_cnt <= w_count_ext[ple_pkg::CNT_OUT_W-1:0];
            r_empty    <= (n_count == '0);
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.result_value  = r_result;
    assign o_rsp.status        = r_status;
    assign o_rsp.element_count = r_elem_cnt;
    assign o_rsp.is_empty      = r_empty;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_dec.cnt_inc |=> r_count == $past(r_count) + {{(CNT_W-1){1'b0}}, 1'b1})
        else $error("successful insert did not grow the list");

    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status == ple_pkg::ST_FULL) |-> r_count == CNT_W'(CAPACITY))
        else $error("full status with room left");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_empty |-> (r_elem_cnt == '0) && (r_count == '0))
        else $error("empty flag disagrees with count");
`endif

endmodule

// File: tb/sv/positional_list_engine_unit_test.sv
module positional_list_engine_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 160;

    // cmd field codes outside the defined set
    localparam logic [ple_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [ple_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd7;

    // burst shapes for the random part
    localparam int BURST_GROW   = 0;
    localparam int BURST_SHRINK = 1;
    localparam int BURST_MIXED  = 2;

    typedef struct packed {
        logic signed [ple_pkg::RES_W-1:0]  result_value;
        ple_pkg::t_status                  status;
        logic [ple_pkg::CNT_OUT_W-1:0]     element_count;
        logic                              is_empty;
    } t_rsp_item;

    class list_scoreboard;
        logic signed [ple_pkg::RES_W-1:0] words [CAPACITY];
        int unsigned             count;
        int unsigned             peak;
        t_rsp_item               pending [$];
        int unsigned             failures;
        int unsigned             checked;
        int unsigned             status_seen [4];

        function new();
            count    = 0;
            peak     = 0;
            failures = 0;
            checked  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        // apply one accepted command to the shadow list and queue its response
        function void note_command(logic [ple_pkg::CMD_W-1:0] c,
                                   logic [ple_pkg::POS_W-1:0] p,
                                   logic signed [ple_pkg::RES_W-1:0] v);
            t_rsp_item exp;
            int        i;
            exp.result_value = '0;
            exp.status       = ple_pkg::ST_OK;
            case (c)
                ple_pkg::CMD_APPEND: begin
                    exp.result_value = v;
                    if (count >= CAPACITY) begin
                        exp.status = ple_pkg::ST_FULL;
                    end else begin
                        words[count] = v;
                        count++;
                    end
                end
                ple_pkg::CMD_INSERT: begin
                    exp.result_value = v;
                    if (p > count) begin
                        exp.status = ple_pkg::ST_BADPOS;
                    end else if (count >= CAPACITY) begin
                        exp.status = ple_pkg::ST_FULL;
                    end else begin
                        for (i = count; i > p; i--) words[i] = words[i-1];
                        words[p] = v;
                        count++;
                    end
                end
                ple_pkg::CMD_REMOVE_FIRST: begin
                    if (count == 0) begin
                        exp.status = ple_pkg::ST_EMPTY;
                    end else begin
                        exp.result_value = words[0];
                        for (i = 0; i + 1 < count; i++) words[i] = words[i+1];
                        count--;
                    end
                end
                ple_pkg::CMD_REMOVE_AT: begin
                    // empty wins over a bad position
                    if (count == 0) begin
                        exp.status = ple_pkg::ST_EMPTY;
                    end else if (p >= count) begin
                        exp.status = ple_pkg::ST_BADPOS;
                    end else begin
                        exp.result_value = words[p];
                        for (i = p; i + 1 < count; i++) words[i] = words[i+1];
                        count--;
                    end
                end
                ple_pkg::CMD_READ: begin
                    if (p >= count) exp.status = ple_pkg::ST_BADPOS;
                    else exp.result_value = words[p];
                end
                ple_pkg::CMD_WRITE: begin
                    exp.result_value = v;
                    if (p >= count) exp.status = ple_pkg::ST_BADPOS;
                    else words[p] = v;
                end
                default: begin
                    exp.status = ple_pkg::ST_BADPOS;
                end
            endcase
            exp.element_count = count[ple_pkg::CNT_OUT_W-1:0];
            exp.is_empty      = (count == 0);
            if (count > peak) peak = count;
            status_seen[exp.status]++;
            pending.push_back(exp);
        endfunction

        function void check_response(t_rsp_item got);
            t_rsp_item exp;
            checked++;
            if (pending.size() == 0) begin
                flag($sformatf("response with nothing outstanding: val=%h st=%0d cnt=%0d empty=%0d",
                               got.result_value, got.status, got.element_count, got.is_empty));
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
                flag($sformatf("exp val=%h st=%0d cnt=%0d empty=%0d, got val=%h st=%0d cnt=%0d empty=%0d",
                               exp.result_value, exp.status, exp.element_count, exp.is_empty,
                               got.result_value, got.status, got.element_count, got.is_empty));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ple_cmd_if cmd_bus ();
    ple_rsp_if rsp_bus ();

    positional_list_engine_unit #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    list_scoreboard book;
    int unsigned    src_idle_pct;
    int unsigned    snk_stall_pct;
    int unsigned    sent;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // response side: check on every transfer, then pick next ready
    initial begin
        t_rsp_item got;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                got.result_value  = rsp_bus.result_value;
                got.status        = ple_pkg::t_status'(rsp_bus.status);
                got.element_count = rsp_bus.element_count;
                got.is_empty      = rsp_bus.is_empty;
                book.check_response(got);
            end
            rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_command(input logic [ple_pkg::CMD_W-1:0] c,
                                input logic [ple_pkg::POS_W-1:0] p,
                                input logic signed [ple_pkg::RES_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.cmd      <= c;
        cmd_bus.position <= p;
        cmd_bus.value    <= v;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        book.note_command(c, p, v);
        sent++;
    endtask

    function automatic logic [ple_pkg::CMD_W-1:0] pick_command(int shape);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) return ($urandom_range(1) != 0) ? CMD_RSVD_A : CMD_RSVD_B;
        case (shape)
            BURST_GROW: begin
                if (r < 45) return ple_pkg::CMD_APPEND;
                if (r < 75) return ple_pkg::CMD_INSERT;
                if (r < 85) return ple_pkg::CMD_READ;
                if (r < 93) return ple_pkg::CMD_WRITE;
                return ($urandom_range(1) != 0) ? ple_pkg::CMD_REMOVE_FIRST
                                                : ple_pkg::CMD_REMOVE_AT;
            end
            BURST_SHRINK: begin
                if (r < 40) return ple_pkg::CMD_REMOVE_FIRST;
                if (r < 75) return ple_pkg::CMD_REMOVE_AT;
                if (r < 85) return ple_pkg::CMD_READ;
                if (r < 92) return ple_pkg::CMD_WRITE;
                return ($urandom_range(1) != 0) ? ple_pkg::CMD_APPEND : ple_pkg::CMD_INSERT;
            end
            default: begin
                return ple_pkg::t_cmd'($urandom_range(ple_pkg::CMD_WRITE));
            end
        endcase
    endfunction

    task automatic random_burst(input int n, input int shape);
        logic [ple_pkg::CMD_W-1:0]        c;
        logic [ple_pkg::POS_W-1:0]        p;
        logic signed [ple_pkg::RES_W-1:0] v;
        int unsigned                      r;
        repeat (n) begin
            c = pick_command(shape);
            // mostly legal positions, some anywhere in the field
            if ($urandom_range(99) < 20)
                p = ple_pkg::POS_W'($urandom_range(255));
            else if (c == ple_pkg::CMD_INSERT)
                p = ple_pkg::POS_W'($urandom_range(book.count));
            else
                p = (book.count == 0) ? '0 : ple_pkg::POS_W'($urandom_range(book.count - 1));
            r = $urandom_range(99);
            if (r < 3)       v = 32'sh8000_0000;
            else if (r < 6)  v = 32'sh7fff_ffff;
            else if (r < 8)  v = '0;
            else if (r < 10) v = -32'sd1;
            else             v = $urandom;
            send_command(c, p, v);
        end
    endtask

    initial begin
        int phase_items;
        int n;
        book          = new();
        sent          = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        i_rst_n          <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.cmd      <= '0;
        cmd_bus.position <= '0;
        cmd_bus.value    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        send_command(ple_pkg::CMD_READ,         8'd0,   32'sd5);
        send_command(ple_pkg::CMD_WRITE,        8'd0,   32'sh1234_5678);
        send_command(ple_pkg::CMD_REMOVE_FIRST, 8'd0,   32'sd0);
        send_command(ple_pkg::CMD_REMOVE_AT,    8'd255, 32'sd0);
        send_command(ple_pkg::CMD_INSERT,       8'd1,   32'sd9);
        // build up with extreme words, insert at front, end and middle
        send_command(ple_pkg::CMD_INSERT,       8'd0,   32'sh7fff_ffff);
        send_command(ple_pkg::CMD_APPEND,       8'd0,   32'sh8000_0000);
        send_command(ple_pkg::CMD_INSERT,       8'd2,   -32'sd1);
        send_command(ple_pkg::CMD_INSERT,       8'd1,   32'sd0);
        for (int i = 0; i < 4; i++) send_command(ple_pkg::CMD_READ, 8'(i), 32'sd0);
        send_command(ple_pkg::CMD_READ,         8'd4,   32'sd0);
        send_command(ple_pkg::CMD_WRITE,        8'd3,   32'shaaaa_aaaa);
        send_command(ple_pkg::CMD_REMOVE_AT,    8'd4,   32'sd0);
        send_command(ple_pkg::CMD_REMOVE_AT,    8'd1,   32'sd0);
        send_command(CMD_RSVD_A,                8'd255, -32'sd1);
        send_command(CMD_RSVD_B,                8'd0,   32'sh5555_5555);
        send_command(ple_pkg::CMD_REMOVE_FIRST, 8'd0,   32'sd0);
        send_command(ple_pkg::CMD_READ,         8'd255, 32'sd0);
        send_command(ple_pkg::CMD_WRITE,        8'd0,   32'sh5555_5555);
        send_command(ple_pkg::CMD_REMOVE_AT,    8'd0,   32'sd0);
        send_command(ple_pkg::CMD_REMOVE_FIRST, 8'd0,   32'sd0);
        send_command(ple_pkg::CMD_INSERT,       8'd0,   32'sd1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
                default: begin src_idle_pct = 7; snk_stall_pct = 7; end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                // grow long enough to hit the full list, drain past empty
                n = $urandom_range(20, 60);
                random_burst(n, $urandom_range(BURST_MIXED));
                phase_items += n;
            end
        end
        cmd_bus.valid <= 1'b0;

        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (book.pending.size() != 0) book.flag("responses still outstanding at end");

        $display("Ran %0d commands, checked %0d responses, peak occupancy %0d of %0d.",
                 sent, book.checked, book.peak, CAPACITY);
        $display("Status mix: ok %0d, bad position %0d, empty %0d, full %0d; %0d mismatches.",
                 book.status_seen[ple_pkg::ST_OK], book.status_seen[ple_pkg::ST_BADPOS],
                 book.status_seen[ple_pkg::ST_EMPTY], book.status_seen[ple_pkg::ST_FULL],
                 book.failures);
        if (book.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
